@@ sv/ffca_pkg.sv @@
// ----------------------------------------------------------------------------
// ffca_pkg: shared types and constants for the first-fit allocator
// Field widths, status codes, request and result words, and sequencer states.
// ----------------------------------------------------------------------------
package ffca_pkg;

    // Widths of addresses, lengths and rounded sizes (one spare bit for overflow).
    localparam int ADDR_W = 32;
    localparam int LEN_W  = 24;
    localparam int SIZE_W = LEN_W + 1;

    // Allocation granule; a power of two so rounding is an add and a mask.
    localparam int unsigned GRAIN = 16;
    localparam logic [SIZE_W-1:0] GRAIN_MASK = SIZE_W'(GRAIN - 1);

    localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

    typedef enum logic {
        KIND_ALLOC = 1'b0,
        KIND_FREE  = 1'b1
    } ffca_kind_t;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_NOMEM   = 2'd1,
        STATUS_DROPPED = 2'd2,
        STATUS_IGNORED = 2'd3
    } ffca_status_t;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        REG_ARENA_START  = 1'b0,
        REG_ARENA_LENGTH = 1'b1
    } ffca_reg_t;

    typedef struct packed {
        logic [ADDR_W-1:0] start;
        logic [LEN_W-1:0]  length;
    } ffca_arena_t;

    // One free-list entry.
    typedef struct packed {
        logic [ADDR_W-1:0] start;
        logic [LEN_W-1:0]  len;
    } ffca_entry_t;

    // Request word handed to the engine; size is already rounded to the granule.
    typedef struct packed {
        ffca_kind_t        kind;
        logic [SIZE_W-1:0] size;
        logic [ADDR_W-1:0] addr;
    } ffca_req_t;

    // Result word returned by the engine.
    typedef struct packed {
        ffca_status_t      status;
        logic [ADDR_W-1:0] granted;
        logic [LEN_W-1:0]  total;
        logic [LEN_W-1:0]  largest;
    } ffca_res_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ASCAN,
        ST_CARVE,
        ST_REMOVE,
        ST_FSCAN,
        ST_FPREV,
        ST_FJOIN,
        ST_FNEXT,
        ST_INSERT,
        ST_PLACE,
        ST_SUM,
        ST_DONE
    } ffca_state_t;

endpackage

@@ sv/ffca_engine.sv @@
// ----------------------------------------------------------------------------
// ffca_engine: free-list sequencer
// Holds the sorted free list in a small memory and walks it one entry per
// cycle through a shared adder and a shared saturating length adder.
// ----------------------------------------------------------------------------
module ffca_engine #(
    parameter int FREE_SLOTS = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  ffca_pkg::ffca_req_t  req,
    input  ffca_pkg::ffca_arena_t arena,
    input  logic                 cfg_clear,
    input  logic                 out_free,
    output logic                 idle,
    output logic                 done,
    output ffca_pkg::ffca_res_t  res
);
    import ffca_pkg::*;

    localparam int IDX_W = $clog2(FREE_SLOTS);
    localparam int CNT_W = $clog2(FREE_SLOTS + 1);
    localparam logic [CNT_W-1:0] SLOTS = CNT_W'(FREE_SLOTS);
    localparam logic [CNT_W-1:0] ONE   = CNT_W'(1);

    // Saturating add of two lengths.
    function automatic logic [LEN_W-1:0] sat_add(input logic [LEN_W-1:0] a,
                                                 input logic [LEN_W-1:0] b);
        logic [LEN_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[LEN_W] ? LEN_MAX : s[LEN_W-1:0];
    endfunction

    ffca_state_t       state_reg, state_next;
    ffca_kind_t        kind_reg, kind_next;
    logic [SIZE_W-1:0] size_reg, size_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    ffca_status_t      status_reg, status_next;
    logic [ADDR_W-1:0] granted_reg, granted_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]  pos_reg, pos_next;
    logic [CNT_W-1:0]  dat_idx_reg;
    logic              loaded_reg, loaded_next;
    logic              prime_reg, prime_next;
    logic              have_prev_reg, have_prev_next;
    ffca_entry_t       prev_reg, prev_next;
    ffca_entry_t       cur_reg, cur_next;
    logic [LEN_W-1:0]  total_reg, total_next;
    logic [LEN_W-1:0]  largest_reg, largest_next;

    // Free-list memory: one write port, one registered read port.
    ffca_entry_t       mem [FREE_SLOTS];
    ffca_entry_t       rd_data_reg;
    logic              mem_we;
    logic [CNT_W-1:0]  mem_waddr;
    ffca_entry_t       mem_wdata;
    logic [CNT_W-1:0]  rd_addr;

    // Shared arithmetic.
    logic [ADDR_W-1:0] add_a, add_b, add_sum;
    logic [LEN_W-1:0]  sat_a, sat_b, sat_sum;
    logic [LEN_W-1:0]  size_len, carve_len;

    // Status flags of the walk.
    logic issue_more, last_data, stream_end;
    logic ins_more, ins_end;
    logic have_cur, full, fits, below;
    logic eff_loaded, early_exit;
    ffca_status_t early_status;
    logic prev_adj, end_meets_cur;

    assign size_len   = size_reg[LEN_W-1:0];
    assign issue_more = idx_reg < count_reg;
    assign last_data  = prime_reg && ((dat_idx_reg + ONE) == count_reg);
    assign stream_end = prime_reg ? last_data : !issue_more;
    assign ins_more   = idx_reg > pos_reg;
    assign ins_end    = prime_reg ? (dat_idx_reg == pos_reg) : !ins_more;
    assign have_cur   = pos_reg < count_reg;
    assign full       = count_reg >= SLOTS;
    assign fits       = {1'b0, rd_data_reg.len} >= size_reg;
    assign below      = rd_data_reg.start < addr_reg;
    assign eff_loaded = loaded_reg || (arena.length != '0);

    // Shared address adder: block end tests and carving.
    always_comb begin
        unique case (state_reg)
            ST_CARVE: begin
                add_a = cur_reg.start;
                add_b = {{(ADDR_W-LEN_W){1'b0}}, size_len};
            end
            ST_FNEXT: begin
                add_a = addr_reg;
                add_b = {{(ADDR_W-LEN_W){1'b0}}, size_len};
            end
            default: begin
                add_a = prev_reg.start;
                add_b = {{(ADDR_W-LEN_W){1'b0}}, prev_reg.len};
            end
        endcase
    end

    assign add_sum       = add_a + add_b;
    assign prev_adj      = have_prev_reg && (add_sum == addr_reg);
    assign end_meets_cur = have_cur && (add_sum == cur_reg.start);
    assign carve_len     = cur_reg.len - size_len;

    // Shared saturating length adder: merges and the running total.
    always_comb begin
        unique case (state_reg)
            ST_FPREV: begin
                sat_a = prev_reg.len;
                sat_b = size_len;
            end
            ST_FJOIN: begin
                sat_a = prev_reg.len;
                sat_b = cur_reg.len;
            end
            ST_FNEXT: begin
                sat_a = cur_reg.len;
                sat_b = size_len;
            end
            default: begin
                sat_a = total_reg;
                sat_b = rd_data_reg.len;
            end
        endcase
    end

    assign sat_sum = sat_add(sat_a, sat_b);

    // Requests that are answered without touching the list.
    always_comb begin
        early_exit   = 1'b1;
        early_status = STATUS_OK;
        if (!eff_loaded) begin
            early_status = (req.kind == KIND_FREE) ? STATUS_IGNORED : STATUS_NOMEM;
        end else if (req.kind == KIND_ALLOC) begin
            early_exit   = req.size[SIZE_W-1];
            early_status = req.size[SIZE_W-1] ? STATUS_NOMEM : STATUS_OK;
        end else begin
            early_exit   = (req.addr == '0) || (req.size == '0) || req.size[SIZE_W-1];
            early_status = early_exit ? STATUS_IGNORED : STATUS_OK;
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    if (early_exit) begin
                        state_next = ST_SUM;
                    end else if (req.kind == KIND_ALLOC) begin
                        state_next = ST_ASCAN;
                    end else begin
                        state_next = ST_FSCAN;
                    end
                end
            end
            ST_ASCAN: begin
                if (prime_reg && fits) begin
                    state_next = ST_CARVE;
                end else if (stream_end) begin
                    state_next = ST_SUM;
                end
            end
            ST_CARVE: begin
                state_next = (carve_len == '0) ? ST_REMOVE : ST_SUM;
            end
            ST_REMOVE: begin
                if (stream_end) begin
                    state_next = ST_SUM;
                end
            end
            ST_FSCAN: begin
                if ((prime_reg && !below) || stream_end) begin
                    state_next = ST_FPREV;
                end
            end
            ST_FPREV: begin
                state_next = prev_adj ? ST_FJOIN : ST_FNEXT;
            end
            ST_FJOIN: begin
                state_next = end_meets_cur ? ST_REMOVE : ST_SUM;
            end
            ST_FNEXT: begin
                state_next = (end_meets_cur || full) ? ST_SUM : ST_INSERT;
            end
            ST_INSERT: begin
                if (ins_end) begin
                    state_next = ST_PLACE;
                end
            end
            ST_PLACE: begin
                state_next = ST_SUM;
            end
            ST_SUM: begin
                if (stream_end) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and memory control.
    always_comb begin
        kind_next      = kind_reg;
        size_next      = size_reg;
        addr_next      = addr_reg;
        status_next    = status_reg;
        granted_next   = granted_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        pos_next       = pos_reg;
        loaded_next    = loaded_reg;
        prime_next     = 1'b0;
        have_prev_next = have_prev_reg;
        prev_next      = prev_reg;
        cur_next       = cur_reg;
        total_next     = total_reg;
        largest_next   = largest_reg;
        mem_we         = 1'b0;
        mem_waddr      = pos_reg;
        mem_wdata      = rd_data_reg;
        rd_addr        = idx_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    kind_next      = req.kind;
                    size_next      = req.size;
                    addr_next      = req.addr;
                    status_next    = early_status;
                    granted_next   = '0;
                    have_prev_next = 1'b0;
                    idx_next       = '0;
                    total_next     = '0;
                    largest_next   = '0;
                    // First item after configuration loads the arena.
                    if (!loaded_reg && (arena.length != '0)) begin
                        mem_we      = 1'b1;
                        mem_waddr   = '0;
                        mem_wdata   = '{start: arena.start, len: arena.length};
                        count_next  = ONE;
                        loaded_next = 1'b1;
                    end
                end else if (cfg_clear) begin
                    count_next  = '0;
                    loaded_next = 1'b0;
                end
            end

            // First fit: stop at the first entry long enough.
            ST_ASCAN: begin
                if (issue_more) begin
                    idx_next = idx_reg + ONE;
                end
                prime_next = issue_more;
                if (prime_reg && fits) begin
                    cur_next = rd_data_reg;
                    pos_next = dat_idx_reg;
                end else if (stream_end) begin
                    status_next = STATUS_NOMEM;
                    idx_next    = '0;
                    prime_next  = 1'b0;
                end
            end

            // Grant the front of the block; an emptied block is removed.
            ST_CARVE: begin
                granted_next = cur_reg.start;
                if (carve_len == '0) begin
                    idx_next = pos_reg + ONE;
                end else begin
                    mem_we    = 1'b1;
                    mem_waddr = pos_reg;
                    mem_wdata = '{start: add_sum, len: carve_len};
                    idx_next  = '0;
                end
            end

            // Shift entries above the removed one down by one place.
            ST_REMOVE: begin
                if (issue_more) begin
                    idx_next = idx_reg + ONE;
                end
                prime_next = issue_more;
                if (prime_reg) begin
                    mem_we    = 1'b1;
                    mem_waddr = dat_idx_reg - ONE;
                    mem_wdata = rd_data_reg;
                end
                if (stream_end) begin
                    count_next = count_reg - ONE;
                    idx_next   = '0;
                    prime_next = 1'b0;
                end
            end

            // Find the first entry at or above the freed base.
            ST_FSCAN: begin
                if (issue_more) begin
                    idx_next = idx_reg + ONE;
                end
                prime_next = issue_more;
                if (prime_reg) begin
                    if (below) begin
                        prev_next      = rd_data_reg;
                        have_prev_next = 1'b1;
                        if (last_data) begin
                            pos_next = count_reg;
                        end
                    end else begin
                        pos_next = dat_idx_reg;
                        cur_next = rd_data_reg;
                    end
                end else if (!issue_more) begin
                    pos_next = count_reg;
                end
            end

            // Grow the block below when it ends at the freed base.
            ST_FPREV: begin
                if (prev_adj) begin
                    prev_next.len = sat_sum;
                end
            end

            // The grown block may now reach the block above: join them.
            ST_FJOIN: begin
                mem_we    = 1'b1;
                mem_waddr = pos_reg - ONE;
                if (end_meets_cur) begin
                    mem_wdata = '{start: prev_reg.start, len: sat_sum};
                    idx_next  = pos_reg + ONE;
                end else begin
                    mem_wdata = prev_reg;
                    idx_next  = '0;
                end
            end

            // Merge into the block above, or make room for a new entry.
            ST_FNEXT: begin
                if (end_meets_cur) begin
                    mem_we    = 1'b1;
                    mem_waddr = pos_reg;
                    mem_wdata = '{start: addr_reg, len: sat_sum};
                    idx_next  = '0;
                end else if (full) begin
                    status_next = STATUS_DROPPED;
                    idx_next    = '0;
                end else begin
                    idx_next = count_reg;
                end
            end

            // Shift entries from the insert point upward by one place.
            ST_INSERT: begin
                rd_addr = idx_reg - ONE;
                if (ins_more) begin
                    idx_next = idx_reg - ONE;
                end
                prime_next = ins_more;
                if (prime_reg) begin
                    mem_we    = 1'b1;
                    mem_waddr = dat_idx_reg + ONE;
                    mem_wdata = rd_data_reg;
                end
            end

            ST_PLACE: begin
                mem_we     = 1'b1;
                mem_waddr  = pos_reg;
                mem_wdata  = '{start: addr_reg, len: size_len};
                count_next = count_reg + ONE;
                idx_next   = '0;
            end

            // Running total and largest block over the whole list.
            ST_SUM: begin
                if (issue_more) begin
                    idx_next = idx_reg + ONE;
                end
                prime_next = issue_more;
                if (prime_reg) begin
                    total_next = sat_sum;
                    if (rd_data_reg.len > largest_reg) begin
                        largest_next = rd_data_reg.len;
                    end
                end
                if (stream_end) begin
                    prime_next = 1'b0;
                end
            end

            ST_DONE: begin
                idx_next = '0;
            end

            default: begin
                idx_next = '0;
            end
        endcase
    end

    // Outputs toward the top level.
    always_comb begin
        idle        = state_reg == ST_IDLE;
        done        = (state_reg == ST_DONE) && out_free;
        res.status  = status_reg;
        res.granted = granted_reg;
        res.total   = total_reg;
        res.largest = largest_reg;
    end

    // Memory write and registered read.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr[IDX_W-1:0]] <= mem_wdata;
        end
        rd_data_reg <= mem[rd_addr[IDX_W-1:0]];
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            loaded_reg    <= 1'b0;
            idx_reg       <= '0;
            pos_reg       <= '0;
            dat_idx_reg   <= '0;
            prime_reg     <= 1'b0;
            have_prev_reg <= 1'b0;
            status_reg    <= STATUS_OK;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            loaded_reg    <= loaded_next;
            idx_reg       <= idx_next;
            pos_reg       <= pos_next;
            dat_idx_reg   <= rd_addr;
            prime_reg     <= prime_next;
            have_prev_reg <= have_prev_next;
            status_reg    <= status_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        kind_reg    <= kind_next;
        size_reg    <= size_next;
        addr_reg    <= addr_next;
        granted_reg <= granted_next;
        prev_reg    <= prev_next;
        cur_reg     <= cur_next;
        total_reg   <= total_next;
        largest_reg <= largest_next;
    end

endmodule

@@ sv/first_fit_coalescing_allocator.sv @@
// ----------------------------------------------------------------------------
// first_fit_coalescing_allocator: first-fit arena allocator with coalescing
// Each pass over the free list (search, shift, then totals) reads one entry per
// cycle from one read port. Throughput: one word at a time; s_ready is low from
// acceptance until the result moves into the output register. Reset empties the
// list, no sweep.
// ----------------------------------------------------------------------------
module first_fit_coalescing_allocator #(
    parameter int FREE_SLOTS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input words.
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_kind,
    input  logic [23:0] s_request_bytes,
    input  logic [31:0] s_segment_address,
    // Result words.
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [31:0] m_granted_address,
    output logic [23:0] m_total_free,
    output logic [23:0] m_largest_block,
    // Configuration writes.
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [31:0] cfg_wdata
);
    import ffca_pkg::*;

    ffca_arena_t arena_reg;
    ffca_req_t   req;
    ffca_res_t   eng_res;
    ffca_res_t   m_res_reg;
    logic        m_valid_reg, m_valid_next;
    logic        eng_idle, eng_done, start, out_free;

    // Request rounding to the granule; the spare bit flags an oversized size.
    assign req.kind = ffca_kind_t'(s_kind);
    assign req.size = ({1'b0, s_request_bytes} + GRAIN_MASK) & ~GRAIN_MASK;
    assign req.addr = s_segment_address;

    assign s_ready  = eng_idle;
    assign start    = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            arena_reg <= '0;
        end else if (cfg_we) begin
            unique case (ffca_reg_t'(cfg_index))
                REG_ARENA_START:  arena_reg.start  <= cfg_wdata;
                REG_ARENA_LENGTH: arena_reg.length <= cfg_wdata[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    ffca_engine #(
        .FREE_SLOTS (FREE_SLOTS)
    ) u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (start),
        .req       (req),
        .arena     (arena_reg),
        .cfg_clear (cfg_we),
        .out_free  (out_free),
        .idle      (eng_idle),
        .done      (eng_done),
        .res       (eng_res)
    );

    // Output register between the engine and the result channel.
    always_comb begin
        m_valid_next = m_valid_reg;
        if (eng_done) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (eng_done) begin
            m_res_reg <= eng_res;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_status          = m_res_reg.status;
    assign m_granted_address = m_res_reg.granted;
    assign m_total_free      = m_res_reg.total;
    assign m_largest_block   = m_res_reg.largest;

`ifndef SYNTHESIS
    // An address is granted only by a successful allocate.
    a_grant_only_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != STATUS_OK) |-> m_granted_address == '0)
        else $error("granted address on a failed or non-allocate word");

    // The saturated total never falls below the largest block.
    a_total_covers_largest: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_total_free >= m_largest_block)
        else $error("total free below largest block");

    // An accepted word keeps the engine busy in the next cycle.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("engine ready right after accepting a word");
`endif

endmodule

@@ test/free_list_shadow.sv @@
// ----------------------------------------------------------------------------
// free_list_shadow: prediction and comparison for the first-fit allocator
// Keeps its own copy of the arena registers and the sorted free list, works
// out the result word of every accepted request word, and compares each
// accepted result word with the oldest prediction still owed.
// ----------------------------------------------------------------------------
module free_list_shadow #(
    parameter int SLOTS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic        s_kind,
    input  logic [23:0] s_request_bytes,
    input  logic [31:0] s_segment_address,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [1:0]  m_status,
    input  logic [31:0] m_granted_address,
    input  logic [23:0] m_total_free,
    input  logic [23:0] m_largest_block,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [31:0] cfg_wdata,
    output int          mismatches,
    output int          owed
);
    import ffca_pkg::*;

    // Shadow free list, sorted by start address; only entries below fl_count are live.
    logic [ADDR_W-1:0] fl_start [SLOTS];
    logic [LEN_W-1:0]  fl_len   [SLOTS];
    int                fl_count;
    bit                arena_loaded;
    logic [ADDR_W-1:0] arena_base;
    logic [LEN_W-1:0]  arena_span;
    ffca_res_t         owed_results[$];

    // Round a byte count up to the granule; the result may need one bit more.
    function automatic logic [SIZE_W-1:0] to_grain(logic [LEN_W-1:0] n);
        logic [31:0] wide;
        wide = ((32'(n) + GRAIN - 1) / GRAIN) * GRAIN;
        return wide[SIZE_W-1:0];
    endfunction

    // Length addition that saturates at the largest 24-bit value.
    function automatic logic [LEN_W-1:0] len_sum(logic [LEN_W-1:0] a, logic [LEN_W-1:0] b);
        logic [LEN_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s > {1'b0, LEN_MAX}) ? LEN_MAX : s[LEN_W-1:0];
    endfunction

    // Close the gap left by entry idx.
    task automatic drop_entry(input int idx);
        for (int k = idx + 1; k < fl_count; k++) begin
            fl_start[k-1] = fl_start[k];
            fl_len[k-1]   = fl_len[k];
        end
        if (fl_count > 0)
            fl_count--;
    endtask

    // First fit: carve the request from the front of the first block big enough.
    task automatic carve(input logic [SIZE_W-1:0] need, output ffca_status_t st,
                         output logic [ADDR_W-1:0] granted);
        st      = STATUS_NOMEM;
        granted = '0;
        if (need <= {1'b0, LEN_MAX}) begin
            for (int i = 0; i < fl_count; i++) begin
                if (st != STATUS_OK && {1'b0, fl_len[i]} >= need) begin
                    st          = STATUS_OK;
                    granted     = fl_start[i];
                    fl_start[i] = fl_start[i] + ADDR_W'(need);
                    fl_len[i]   = fl_len[i] - need[LEN_W-1:0];
                    if (fl_len[i] == '0)
                        drop_entry(i);
                end
            end
        end
    endtask

    // Give a segment back: merge below, above, both, or insert a new block.
    task automatic return_segment(input logic [ADDR_W-1:0] base, input logic [SIZE_W-1:0] size,
                                  output ffca_status_t st);
        int                pos;
        logic [ADDR_W-1:0] seg_end;
        logic [LEN_W-1:0]  sz;
        pos = 0;
        if (base == '0 || size == '0 || size > {1'b0, LEN_MAX}) begin
            st = STATUS_IGNORED;
        end else begin
            sz      = size[LEN_W-1:0];
            seg_end = base + ADDR_W'(sz);
            while (pos < fl_count && fl_start[pos] < base)
                pos++;
            if (pos > 0 && fl_start[pos-1] + ADDR_W'(fl_len[pos-1]) == base) begin
                fl_len[pos-1] = len_sum(fl_len[pos-1], sz);
                if (pos < fl_count &&
                    fl_start[pos-1] + ADDR_W'(fl_len[pos-1]) == fl_start[pos]) begin
                    fl_len[pos-1] = len_sum(fl_len[pos-1], fl_len[pos]);
                    drop_entry(pos);
                end
                st = STATUS_OK;
            end else if (pos < fl_count && seg_end == fl_start[pos]) begin
                fl_start[pos] = base;
                fl_len[pos]   = len_sum(fl_len[pos], sz);
                st            = STATUS_OK;
            end else if (fl_count >= SLOTS) begin
                st = STATUS_DROPPED;
            end else begin
                for (int k = fl_count; k > pos; k--) begin
                    fl_start[k] = fl_start[k-1];
                    fl_len[k]   = fl_len[k-1];
                end
                fl_start[pos] = base;
                fl_len[pos]   = sz;
                fl_count++;
                st = STATUS_OK;
            end
        end
    endtask

    // Full prediction of one request word, totals included.
    task automatic shadow_apply(input ffca_kind_t kind, input logic [LEN_W-1:0] bytes,
                                input logic [ADDR_W-1:0] addr, output ffca_res_t res);
        ffca_status_t      st;
        logic [ADDR_W-1:0] granted;
        logic [LEN_W-1:0]  total;
        logic [LEN_W-1:0]  largest;
        granted = '0;
        total   = '0;
        largest = '0;
        // The first word after a configuration change loads the whole arena.
        if (!arena_loaded && arena_span != '0) begin
            fl_start[0]  = arena_base;
            fl_len[0]    = arena_span;
            fl_count     = 1;
            arena_loaded = 1'b1;
        end
        if (!arena_loaded) begin
            if (kind == KIND_FREE)
                st = STATUS_IGNORED;
            else
                st = STATUS_NOMEM;
        end else if (kind == KIND_ALLOC) begin
            carve(to_grain(bytes), st, granted);
        end else begin
            return_segment(addr, to_grain(bytes), st);
        end
        if (st != STATUS_OK || kind != KIND_ALLOC)
            granted = '0;
        for (int i = 0; i < fl_count; i++) begin
            total = len_sum(total, fl_len[i]);
            if (fl_len[i] > largest)
                largest = fl_len[i];
        end
        res.status  = st;
        res.granted = granted;
        res.total   = total;
        res.largest = largest;
    endtask

    // Configuration writes, then new requests, then result words, all per edge.
    always @(posedge aclk) begin : watch
        ffca_res_t predicted;
        ffca_res_t seen;
        if (!aresetn) begin
            fl_count     = 0;
            arena_loaded = 1'b0;
            arena_base   = '0;
            arena_span   = '0;
            owed_results.delete();
            mismatches   = 0;
        end else begin
            if (cfg_we) begin
                if (cfg_index == REG_ARENA_START)
                    arena_base = cfg_wdata;
                else
                    arena_span = cfg_wdata[LEN_W-1:0];
                arena_loaded = 1'b0;
                fl_count     = 0;
            end
            if (s_valid && s_ready) begin
                shadow_apply(ffca_kind_t'(s_kind), s_request_bytes, s_segment_address,
                             predicted);
                owed_results.push_back(predicted);
            end
            if (m_valid && m_ready) begin
                seen.status  = ffca_status_t'(m_status);
                seen.granted = m_granted_address;
                seen.total   = m_total_free;
                seen.largest = m_largest_block;
                if (owed_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result word with nothing owed: status %0d granted %h",
                                 seen.status, seen.granted,
                                 " total %h largest %h", seen.total, seen.largest);
                end else begin
                    predicted = owed_results.pop_front();
                    if (predicted.status != seen.status || predicted.granted != seen.granted ||
                        predicted.total != seen.total || predicted.largest != seen.largest) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result word differs: expected status %0d granted %h",
                                     predicted.status, predicted.granted,
                                     " total %h largest %h,",
                                     predicted.total, predicted.largest,
                                     " got status %0d granted %h",
                                     seen.status, seen.granted,
                                     " total %h largest %h", seen.total, seen.largest);
                    end
                end
            end
        end
        owed = owed_results.size();
    end

endmodule

@@ test/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: top level for the first-fit coalescing allocator
// Drives request words, configuration writes and receiver back-pressure in
// several pacing phases over several arena settings; the free list shadow
// beside the block predicts and compares every result word.
// ----------------------------------------------------------------------------
module testbench;
    import ffca_pkg::*;

    localparam int CYCLE_LIMIT      = 600000;
    localparam int DRAIN_CYCLES     = 64;
    localparam int HOLD_CYCLES      = 300;
    localparam int RANDOM_PER_PHASE = 55;

    typedef enum int {
        PACE_FULL,
        PACE_TX_IDLE,
        PACE_RX_STALL,
        PACE_BOTH
    } pace_t;

    // A granted segment that may be handed back later.
    typedef struct {
        logic [31:0] addr;
        logic [23:0] bytes;
    } segment_t;

    typedef struct {
        logic        kind;
        logic [23:0] bytes;
    } issued_t;

    logic        aclk              = 1'b0;
    logic        aresetn           = 1'b0;
    logic        s_valid           = 1'b0;
    logic        s_ready;
    logic        s_kind            = 1'b0;
    logic [23:0] s_request_bytes   = '0;
    logic [31:0] s_segment_address = '0;
    logic        m_valid;
    logic        m_ready           = 1'b0;
    logic [1:0]  m_status;
    logic [31:0] m_granted_address;
    logic [23:0] m_total_free;
    logic [23:0] m_largest_block;
    logic        cfg_we            = 1'b0;
    logic [0:0]  cfg_index         = '0;
    logic [31:0] cfg_wdata         = '0;

    pace_t       pace      = PACE_FULL;
    int          hold_asks = 0;
    int          cycles    = 0;
    int          mismatches;
    int          owed;
    logic [31:0] arena_base_now = '0;
    logic [23:0] arena_len_now  = '0;
    segment_t    live_segments[$];
    issued_t     issued_words[$];

    always #5 aclk = ~aclk;

    first_fit_coalescing_allocator uut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_kind            (s_kind),
        .s_request_bytes   (s_request_bytes),
        .s_segment_address (s_segment_address),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_status          (m_status),
        .m_granted_address (m_granted_address),
        .m_total_free      (m_total_free),
        .m_largest_block   (m_largest_block),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata)
    );

    free_list_shadow shadow (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_kind            (s_kind),
        .s_request_bytes   (s_request_bytes),
        .s_segment_address (s_segment_address),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_status          (m_status),
        .m_granted_address (m_granted_address),
        .m_total_free      (m_total_free),
        .m_largest_block   (m_largest_block),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata),
        .mismatches        (mismatches),
        .owed              (owed)
    );

    // Watchdog against a hung handshake.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic int tx_idle_pct();
        case (pace)
            PACE_TX_IDLE: return 79;
            PACE_BOTH:    return 21;
            default:      return 0;
        endcase
    endfunction

    function automatic int rx_stall_pct();
        case (pace)
            PACE_RX_STALL: return 79;
            PACE_BOTH:     return 21;
            default:       return 0;
        endcase
    endfunction

    // Receiver pacing, with a long hold-off whenever the stimulus asks for one.
    initial begin : rx_pace
        int served;
        int hold_left;
        served    = 0;
        hold_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_left == 0 && served != hold_asks) begin
                served    = hold_asks;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready = 1'b0;
            end else begin
                m_ready = ($urandom_range(99) >= rx_stall_pct());
            end
        end
    end

    // Learn granted segments from the result words so later frees are well formed.
    always @(posedge aclk) begin : grant_watch
        issued_t done;
        if (m_valid && m_ready && issued_words.size() > 0) begin
            done = issued_words.pop_front();
            if (done.kind == KIND_ALLOC && m_status == STATUS_OK && done.bytes != '0)
                live_segments.push_back('{m_granted_address, done.bytes});
        end
    end

    // Offer one request word and wait for it to be taken; valid stays high after.
    task automatic send_word(input logic kind, input logic [23:0] bytes, input logic [31:0] addr);
        while (tx_idle_pct() > 0 && $urandom_range(99) < tx_idle_pct()) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid           = 1'b1;
        s_kind            = kind;
        s_request_bytes   = bytes;
        s_segment_address = addr;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        issued_words.push_back('{kind, bytes});
        @(negedge aclk);
    endtask

    task automatic write_reg(input ffca_reg_t idx, input logic [31:0] value);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_wdata = value;
        @(negedge aclk);
        cfg_we = 1'b0;
    endtask

    // Both registers; any stale segments belong to the old arena.
    task automatic set_arena(input logic [31:0] base, input logic [31:0] size_word);
        write_reg(REG_ARENA_START, base);
        write_reg(REG_ARENA_LENGTH, size_word);
        arena_base_now = base;
        arena_len_now  = size_word[23:0];
        live_segments.delete();
    endtask

    // Stop offering, wait for every owed result word, then let the engine settle.
    task automatic drain();
        s_valid = 1'b0;
        while (owed != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // Hand back a granted segment, whole or just its front half.
    task automatic free_live();
        int          idx;
        segment_t    seg;
        logic [31:0] rounded;
        logic [31:0] half;
        idx     = $urandom_range(live_segments.size() - 1);
        seg     = live_segments[idx];
        rounded = ((32'(seg.bytes) + GRAIN - 1) / GRAIN) * GRAIN;
        if (rounded >= 32 && $urandom_range(99) < 30) begin
            half = (rounded / 32) * 16;
            live_segments[idx] = '{seg.addr + half, 24'(rounded - half)};
            send_word(KIND_FREE, 24'(half), seg.addr);
        end else begin
            live_segments.delete(idx);
            send_word(KIND_FREE, seg.bytes, seg.addr);
        end
    endtask

    // Frees scattered past the arena end with gaps between them, to fill the list.
    task automatic scatter_burst();
        int          n;
        logic [31:0] base;
        n    = $urandom_range(20, 12);
        base = arena_base_now + 32'(arena_len_now) + 32'h100;
        for (int k = 0; k < n; k++)
            send_word(KIND_FREE, 24'd16, base + 32'(k * 32));
    endtask

    // Mostly allocate and free of granted segments, some noise and one burst.
    task automatic random_phase(input int items, input bit with_hold);
        int          burst_at;
        int          r;
        logic [23:0] sz;
        burst_at = $urandom_range(items - 1);
        for (int i = 0; i < items; i++) begin
            if (with_hold && i == 20)
                hold_asks++;
            if (i == burst_at)
                scatter_burst();
            r = $urandom_range(99);
            if (r < 10) begin
                send_word(1'($urandom_range(1)), 24'($urandom), $urandom);
            end else if (r < 50 && live_segments.size() > 0) begin
                free_live();
            end else begin
                r = $urandom_range(99);
                if (r < 85)
                    sz = 24'($urandom_range(300));
                else if (r < 95)
                    sz = 24'($urandom_range(4096));
                else
                    sz = 24'($urandom);
                send_word(KIND_ALLOC, sz, $urandom);
            end
        end
    endtask

    initial begin : stimulus
        logic [31:0] b;
        repeat (10) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // Arena not ready: nothing loaded, allocate gets no memory, free is ignored.
        send_word(KIND_ALLOC, 24'd64, 32'h0);
        send_word(KIND_FREE, 24'd32, 32'h100);
        drain();

        // Small arena; junk above bit 23 of the length write must be dropped.
        b = 32'h2000_0000;
        set_arena(b, 32'hFF00_0200);
        send_word(KIND_ALLOC, 24'd0, 32'hFFFF_FFFF);      // zero size: first block start
        send_word(KIND_ALLOC, 24'd1, 32'h0);
        send_word(KIND_ALLOC, 24'hFF_FFFF, 32'h0);        // rounds past 24 bits
        send_word(KIND_ALLOC, 24'hFF_FFF0, 32'h0);        // larger than any block
        send_word(KIND_FREE, 24'd16, 32'h0);              // address zero
        send_word(KIND_FREE, 24'd0, b);                   // size zero
        send_word(KIND_FREE, 24'hFF_FFFF, b + 32'h100);   // oversized free
        send_word(KIND_ALLOC, 24'd33, 32'h0);
        send_word(KIND_ALLOC, 24'd100, 32'h0);
        send_word(KIND_FREE, 24'd16, b);                  // insert ahead of the list
        send_word(KIND_FREE, 24'd112, b + 32'd64);        // merge with the block above
        send_word(KIND_FREE, 24'd48, b + 32'd16);         // merge on both sides
        send_word(KIND_ALLOC, 24'd512, 32'h0);            // exact fit empties the list
        send_word(KIND_ALLOC, 24'd0, 32'h0);              // zero size on an empty list
        send_word(KIND_ALLOC, 24'd16, 32'h0);
        send_word(KIND_FREE, 24'd16, b + 32'd256);        // insert into an empty list
        drain();

        // Largest arena: a merge of memory never granted saturates the length.
        set_arena(32'h4000_0000, 32'h00FF_FFFF);
        send_word(KIND_FREE, 24'd16, 32'h40FF_FFFF);
        send_word(KIND_ALLOC, 24'hFF_FFFF, 32'h0);
        send_word(KIND_ALLOC, 24'hFF_FFF1, 32'h0);
        send_word(KIND_ALLOC, 24'd1, 32'h0);
        drain();

        // Random phases over several arenas and pacing patterns.
        pace = PACE_FULL;
        set_arena(32'h1000_0000, 32'd4096);
        random_phase(RANDOM_PER_PHASE, 1'b1);
        drain();

        pace = PACE_TX_IDLE;
        set_arena(32'h0000_0000, 32'd2000);
        random_phase(RANDOM_PER_PHASE, 1'b0);
        drain();

        pace = PACE_RX_STALL;
        set_arena(32'hFFFF_F800, 32'd4096);
        random_phase(RANDOM_PER_PHASE, 1'b0);
        drain();

        // A lone length write also empties the list and reloads the arena.
        pace = PACE_BOTH;
        write_reg(REG_ARENA_LENGTH, 32'hA500_0400);
        arena_len_now = 24'h400;
        live_segments.delete();
        random_phase(RANDOM_PER_PHASE, 1'b0);
        drain();

        pace = PACE_FULL;
        set_arena(32'hFFFF_FFF0, 32'hFFFF_FFFF);
        random_phase(RANDOM_PER_PHASE, 1'b0);
        drain();

        pace = PACE_BOTH;
        set_arena($urandom, 32'd600);
        random_phase(RANDOM_PER_PHASE, 1'b0);
        drain();

        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

@@ sim.f @@
sv/ffca_pkg.sv
sv/ffca_engine.sv
sv/first_fit_coalescing_allocator.sv
test/free_list_shadow.sv
test/testbench.sv
